### rtl/core/pkswl_pkg.sv
// package: shared types and constants for the per-key sliding window limiter
`default_nettype none
package pkswl_pkg;

  localparam int KEY_ENTRIES_DEF = 16;
  localparam int STAMP_SLOTS_DEF = 16;

  localparam int KEY_W    = 32;
  localparam int TIME_W   = 32;
  localparam int CFG_W    = 16;
  localparam int CFG_IDX_W = 1;
  localparam int FRESH_W  = 7;

  localparam logic [CFG_W-1:0] MAX_PER_WINDOW_RST = 16'd10;
  localparam logic [CFG_W-1:0] WINDOW_SECONDS_RST = 16'd3600;

  localparam logic [CFG_IDX_W-1:0] REG_MAX_PER_WINDOW = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_WINDOW_SECONDS = 1'd1;

  typedef enum logic [1:0] {
    VERDICT_ALLOWED  = 2'd0,
    VERDICT_LIMITED  = 2'd1,
    VERDICT_DISABLED = 2'd2,
    VERDICT_FULL     = 2'd3
  } verdict_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_KSCAN,
    ST_MREAD,
    ST_SSCAN,
    ST_DECIDE
  } state_t;

  typedef struct packed {
    logic     load;
    logic     kscan;
    logic     alloc;
    logic     sinit;
    logic     sscan;
    logic     record;
    logic     emit;
    verdict_t code;
  } cmd_t;

  typedef struct packed {
    logic max_zero;
    logic hit;
    logic kdone;
    logic table_full;
    logic sdone;
    logic over;
  } status_t;

endpackage
`default_nettype wire

### rtl/core/pkswl_ctrl.sv
// controller: sequences key scan, allocation, stamp scan and decision
`default_nettype none
module pkswl_ctrl (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              start,
  input  wire pkswl_pkg::status_t stat,
  output pkswl_pkg::cmd_t        cmd,
  output logic                   busy,
  output logic                   done
);

  pkswl_pkg::state_t state;
  pkswl_pkg::state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= pkswl_pkg::ST_IDLE;
      done  <= 1'b0;
    end else begin
      state <= state_next;
      done  <= cmd.emit;
    end
  end

  always_comb begin
    state_next = state;
    cmd        = '0;
    cmd.code   = pkswl_pkg::VERDICT_ALLOWED;
    case (state)
      pkswl_pkg::ST_IDLE: begin
        if (start) begin
          if (stat.max_zero) begin
            cmd.emit = 1'b1;
            cmd.code = pkswl_pkg::VERDICT_DISABLED;
          end else begin
            cmd.load   = 1'b1;
            state_next = pkswl_pkg::ST_KSCAN;
          end
        end
      end
      pkswl_pkg::ST_KSCAN: begin
        cmd.kscan = 1'b1;
        if (stat.hit) begin
          state_next = pkswl_pkg::ST_MREAD;
        end else if (stat.kdone) begin
          if (stat.table_full) begin
            cmd.emit   = 1'b1;
            cmd.code   = pkswl_pkg::VERDICT_FULL;
            state_next = pkswl_pkg::ST_IDLE;
          end else begin
            cmd.alloc  = 1'b1;
            state_next = pkswl_pkg::ST_MREAD;
          end
        end
      end
      pkswl_pkg::ST_MREAD: begin
        cmd.sinit  = 1'b1;
        state_next = pkswl_pkg::ST_SSCAN;
      end
      pkswl_pkg::ST_SSCAN: begin
        cmd.sscan = 1'b1;
        if (stat.sdone) begin
          state_next = pkswl_pkg::ST_DECIDE;
        end
      end
      pkswl_pkg::ST_DECIDE: begin
        cmd.emit = 1'b1;
        if (stat.over) begin
          cmd.code = pkswl_pkg::VERDICT_LIMITED;
        end else begin
          cmd.record = 1'b1;
          cmd.code   = pkswl_pkg::VERDICT_ALLOWED;
        end
        state_next = pkswl_pkg::ST_IDLE;
      end
      default: begin
        state_next = pkswl_pkg::ST_IDLE;
      end
    endcase
  end

  assign busy = (state != pkswl_pkg::ST_IDLE);

endmodule
`default_nettype wire

### rtl/core/pkswl_dp.sv
// datapath: config registers, key table, ring memories and fresh counter
`default_nettype none
module pkswl_dp #(
  parameter int KEY_ENTRIES = pkswl_pkg::KEY_ENTRIES_DEF,
  parameter int STAMP_SLOTS = pkswl_pkg::STAMP_SLOTS_DEF
) (
  input  wire logic                           clk,
  input  wire logic                           rst,
  input  wire pkswl_pkg::cmd_t                cmd,
  output pkswl_pkg::status_t                  stat,
  input  wire logic                           cfg_we,
  input  wire logic [pkswl_pkg::CFG_IDX_W-1:0] cfg_index,
  input  wire logic [pkswl_pkg::CFG_W-1:0]    cfg_data,
  input  wire logic [pkswl_pkg::KEY_W-1:0]    key,
  input  wire logic [pkswl_pkg::TIME_W-1:0]   now_seconds,
  output logic [1:0]                          verdict,
  output logic [pkswl_pkg::FRESH_W-1:0]       fresh_count
);

  localparam int IW = (KEY_ENTRIES > 1) ? $clog2(KEY_ENTRIES) : 1;
  localparam int CW = $clog2(KEY_ENTRIES + 1);
  localparam int SW = (STAMP_SLOTS > 1) ? $clog2(STAMP_SLOTS) : 1;
  localparam int FW = $clog2(STAMP_SLOTS + 1);
  localparam int DEPTH = KEY_ENTRIES * STAMP_SLOTS;
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int KW = pkswl_pkg::KEY_W;
  localparam int TW = pkswl_pkg::TIME_W;
  localparam int RW = pkswl_pkg::CFG_W;
  localparam int XW = pkswl_pkg::FRESH_W;

  logic [KW-1:0] kmem [KEY_ENTRIES];
  logic [SW-1:0] cmem [KEY_ENTRIES];
  logic [FW-1:0] fmem [KEY_ENTRIES];
  logic [TW-1:0] smem [DEPTH];

  logic [RW-1:0] max_reg;
  logic [RW-1:0] win_reg;
  logic [CW-1:0] used;
  logic [KW-1:0] key_q;
  logic [TW-1:0] now_q;
  logic [CW-1:0] kidx;
  logic [IW-1:0] pend_kidx;
  logic          pend;
  logic [KW-1:0] key_rd;
  logic [IW-1:0] slot;
  logic [SW-1:0] cur_rd;
  logic [FW-1:0] fill_rd;
  logic [FW-1:0] sidx;
  logic [TW-1:0] stamp_rd;
  logic [XW-1:0] fresh;
  logic [1:0]    verdict_q;
  logic [XW-1:0] fresh_q;

  logic          hit;
  logic          k_issue;
  logic          s_issue;
  logic [AW-1:0] s_base;
  logic [AW-1:0] s_rd_addr;
  logic [AW-1:0] s_wr_addr;
  logic [TW-1:0] age;
  logic          in_window;
  logic [SW-1:0] cur_next;
  logic [FW-1:0] fill_next;

  assign hit       = cmd.kscan && pend && (key_rd == key_q);
  assign k_issue   = cmd.kscan && !hit && (kidx < used);
  assign s_issue   = cmd.sscan && (sidx < fill_rd);
  assign s_base    = AW'(slot) * AW'(STAMP_SLOTS);
  assign s_rd_addr = s_base + AW'(sidx);
  assign s_wr_addr = s_base + AW'(cur_rd);
  assign age       = now_q - stamp_rd;
  assign in_window = (age <= {{(TW-RW){1'b0}}, win_reg});
  assign cur_next  = (cur_rd == SW'(STAMP_SLOTS - 1)) ? '0 : cur_rd + 1'b1;
  assign fill_next = (fill_rd == FW'(STAMP_SLOTS)) ? fill_rd : fill_rd + 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      max_reg <= pkswl_pkg::MAX_PER_WINDOW_RST;
      win_reg <= pkswl_pkg::WINDOW_SECONDS_RST;
      used    <= '0;
      pend    <= 1'b0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          pkswl_pkg::REG_MAX_PER_WINDOW: max_reg <= cfg_data;
          pkswl_pkg::REG_WINDOW_SECONDS: win_reg <= cfg_data;
          default: ;
        endcase
      end
      if (cmd.load || cmd.sinit) begin
        pend <= 1'b0;
      end else if (cmd.kscan) begin
        pend <= k_issue;
      end else if (cmd.sscan) begin
        pend <= s_issue;
      end
      if (cmd.alloc) begin
        used <= used + 1'b1;
      end
    end
  end

  // key table and per-entry ring state
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      key_q <= key;
      now_q <= now_seconds;
      kidx  <= '0;
      fresh <= '0;
    end
    if (k_issue) begin
      key_rd    <= kmem[kidx[IW-1:0]];
      pend_kidx <= kidx[IW-1:0];
      kidx      <= kidx + 1'b1;
    end
    if (hit) begin
      slot <= pend_kidx;
    end
    if (cmd.alloc) begin
      kmem[used[IW-1:0]] <= key_q;
      cmem[used[IW-1:0]] <= '0;
      fmem[used[IW-1:0]] <= '0;
      slot               <= used[IW-1:0];
    end
    if (cmd.record) begin
      cmem[slot] <= cur_next;
      fmem[slot] <= fill_next;
    end
    cur_rd  <= cmem[slot];
    fill_rd <= fmem[slot];
    if (cmd.sinit) begin
      sidx <= '0;
    end
    if (s_issue) begin
      sidx <= sidx + 1'b1;
    end
    if (cmd.sscan && pend && in_window) begin
      fresh <= fresh + 1'b1;
    end
  end

  // timestamp rings
  always_ff @(posedge clk) begin
    if (s_issue) begin
      stamp_rd <= smem[s_rd_addr];
    end
    if (cmd.record) begin
      smem[s_wr_addr] <= now_q;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      verdict_q <= cmd.code;
      if (cmd.code == pkswl_pkg::VERDICT_ALLOWED || cmd.code == pkswl_pkg::VERDICT_LIMITED) begin
        fresh_q <= fresh;
      end else begin
        fresh_q <= '0;
      end
    end
  end

  always_comb begin
    stat            = '0;
    stat.max_zero   = (max_reg == '0);
    stat.hit        = hit;
    stat.kdone      = !pend && !k_issue;
    stat.table_full = (used == CW'(KEY_ENTRIES));
    stat.sdone      = !pend && !s_issue;
    stat.over       = ({{(RW-XW){1'b0}}, fresh} >= max_reg);
  end

  assign verdict     = verdict_q;
  assign fresh_count = fresh_q;

endmodule
`default_nettype wire

### rtl/core/per_key_sliding_window_limiter.sv
// top level: per-key sliding window rate limiter
// done follows start once the key scan has read the table entries (all in use for
// a new key) and the stamp scan the stored stamps; a full table ends after the key scan
// results never stall, next start taken with done
// with limiting disabled done comes in the cycle after start, one item a cycle
// reset sets max_per_window 10, window_seconds 3600 and empties the table
`default_nettype none
module per_key_sliding_window_limiter #(
  parameter int KEY_ENTRIES = pkswl_pkg::KEY_ENTRIES_DEF,
  parameter int STAMP_SLOTS = pkswl_pkg::STAMP_SLOTS_DEF
) (
  input  wire logic                            clk,
  input  wire logic                            rst,
  input  wire logic                            start,
  output logic                                 busy,
  input  wire logic [pkswl_pkg::KEY_W-1:0]     key,
  input  wire logic [pkswl_pkg::TIME_W-1:0]    now_seconds,
  output logic                                 done,
  output logic [1:0]                           verdict,
  output logic [pkswl_pkg::FRESH_W-1:0]        fresh_count,
  input  wire logic                            cfg_valid,
  output logic                                 cfg_ready,
  input  wire logic [pkswl_pkg::CFG_IDX_W-1:0] cfg_index,
  input  wire logic [pkswl_pkg::CFG_W-1:0]     cfg_data
);

  pkswl_pkg::cmd_t    cmd;
  pkswl_pkg::status_t stat;

  assign cfg_ready = ~busy;

  pkswl_ctrl u_ctrl (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .stat  (stat),
    .cmd   (cmd),
    .busy  (busy),
    .done  (done)
  );

  pkswl_dp #(
    .KEY_ENTRIES (KEY_ENTRIES),
    .STAMP_SLOTS (STAMP_SLOTS)
  ) u_dp (
    .clk         (clk),
    .rst         (rst),
    .cmd         (cmd),
    .stat        (stat),
    .cfg_we      (cfg_valid & cfg_ready),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .key         (key),
    .now_seconds (now_seconds),
    .verdict     (verdict),
    .fresh_count (fresh_count)
  );

endmodule
`default_nettype wire

### verif/tb_per_key_sliding_window_limiter.sv
// testbench for the per-key sliding window limiter: directed and random requests checked against a predictor
module tb_per_key_sliding_window_limiter;
  timeunit 1ns;
  timeprecision 1ps;
  import pkswl_pkg::*;

  localparam int ENTRIES      = KEY_ENTRIES_DEF;
  localparam int SLOTS        = STAMP_SLOTS_DEF;
  localparam int REPORT_LIMIT = 10;
  localparam int SETTLE_CYCLES = 5 + ENTRIES + SLOTS;
  localparam int PHASES       = 9;
  localparam int PHASE_ITEMS  = 88;
  localparam int POOL_KEYS    = 12;

  localparam logic [CFG_W-1:0] PHASE_MAX [PHASES] =
    '{16'd10, 16'd1, 16'd65535, 16'd16, 16'd17, 16'd0, 16'd4, 16'd2, 16'd5};
  localparam logic [CFG_W-1:0] PHASE_WINDOW [PHASES] =
    '{16'd3600, 16'd1, 16'd65535, 16'd50, 16'd200, 16'd100, 16'd0, 16'd65535, 16'd20};

  typedef struct {
    verdict_t           verdict;
    logic [FRESH_W-1:0] fresh;
  } verdict_rec_t;

  class verdict_tracker;
    logic [CFG_W-1:0]  max_per_window;
    logic [CFG_W-1:0]  window_seconds;
    int unsigned       entries_used;
    logic [KEY_W-1:0]  entry_key [ENTRIES];
    int unsigned       entry_cursor [ENTRIES];
    int unsigned       entry_fill [ENTRIES];
    logic [TIME_W-1:0] entry_stamps [ENTRIES][SLOTS];
    verdict_rec_t      pending_verdicts [$];
    int                failures;

    function new();
      max_per_window = MAX_PER_WINDOW_RST;
      window_seconds = WINDOW_SECONDS_RST;
      entries_used = 0;
      failures = 0;
      foreach (entry_cursor[i]) begin
        entry_cursor[i] = 0;
        entry_fill[i] = 0;
      end
    endfunction

    function void set_register(logic [CFG_IDX_W-1:0] index, logic [CFG_W-1:0] data);
      case (index)
        REG_MAX_PER_WINDOW: max_per_window = data;
        REG_WINDOW_SECONDS: window_seconds = data;
        default: ;
      endcase
    endfunction

    function void log_request(logic [KEY_W-1:0] req_key, logic [TIME_W-1:0] req_time);
      verdict_rec_t      rec;
      int                slot;
      int unsigned       fresh;
      int unsigned       i;
      logic [TIME_W-1:0] age;
      rec.fresh = '0;
      slot = -1;
      fresh = 0;
      if (max_per_window == 0) begin
        rec.verdict = VERDICT_DISABLED;
      end else begin
        for (i = 0; i < entries_used; i++) begin
          if (slot < 0 && entry_key[i] == req_key) slot = i;
        end
        if (slot < 0 && entries_used >= ENTRIES) begin
          rec.verdict = VERDICT_FULL;
        end else begin
          if (slot < 0) begin
            slot = entries_used;
            entry_key[slot] = req_key;
            entry_cursor[slot] = 0;
            entry_fill[slot] = 0;
            entries_used++;
          end
          for (i = 0; i < entry_fill[slot]; i++) begin
            age = req_time - entry_stamps[slot][i];
            if (age <= window_seconds) fresh++;
          end
          rec.fresh = fresh[FRESH_W-1:0];
          if (fresh >= max_per_window) begin
            rec.verdict = VERDICT_LIMITED;
          end else begin
            rec.verdict = VERDICT_ALLOWED;
            entry_stamps[slot][entry_cursor[slot]] = req_time;
            entry_cursor[slot] = (entry_cursor[slot] + 1) % SLOTS;
            if (entry_fill[slot] < SLOTS) entry_fill[slot]++;
          end
        end
      end
      pending_verdicts.push_back(rec);
    endfunction

    function void match_verdict(logic [1:0] got_verdict, logic [FRESH_W-1:0] got_fresh);
      verdict_rec_t want;
      if (pending_verdicts.size() == 0) begin
        failures++;
        if (failures <= REPORT_LIMIT)
          $display("unexpected result: verdict %0d fresh_count %0d", got_verdict, got_fresh);
        return;
      end
      want = pending_verdicts.pop_front();
      if (got_verdict !== want.verdict || got_fresh !== want.fresh) begin
        failures++;
        if (failures <= REPORT_LIMIT)
          $display("mismatch: verdict %0d fresh_count %0d, expected verdict %0d fresh_count %0d",
                   got_verdict, got_fresh, want.verdict, want.fresh);
      end
    endfunction
  endclass

  logic                 clk = 1'b0;
  logic                 rst = 1'b1;
  logic                 start = 1'b0;
  logic                 busy;
  logic [KEY_W-1:0]     key = '0;
  logic [TIME_W-1:0]    now_seconds = '0;
  logic                 done;
  logic [1:0]           verdict;
  logic [FRESH_W-1:0]   fresh_count;
  logic                 cfg_valid = 1'b0;
  logic                 cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [CFG_W-1:0]     cfg_data = '0;

  verdict_tracker tracker;

  per_key_sliding_window_limiter dut (
    .clk         (clk),
    .rst         (rst),
    .start       (start),
    .busy        (busy),
    .key         (key),
    .now_seconds (now_seconds),
    .done        (done),
    .verdict     (verdict),
    .fresh_count (fresh_count),
    .cfg_valid   (cfg_valid),
    .cfg_ready   (cfg_ready),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  always @(posedge clk) begin
    if (!rst && done === 1'b1) tracker.match_verdict(verdict, fresh_count);
  end

  // start stays high on return so that a back-to-back request needs no toggle
  task automatic send_request(logic [KEY_W-1:0] req_key, logic [TIME_W-1:0] req_time);
    @(negedge clk);
    start <= 1'b1;
    key <= req_key;
    now_seconds <= req_time;
    do @(posedge clk); while (busy !== 1'b0);
    tracker.log_request(req_key, req_time);
  endtask

  task automatic hold_off(int cycles);
    if (cycles > 0) begin
      @(negedge clk);
      start <= 1'b0;
      repeat (cycles - 1) @(negedge clk);
    end
  endtask

  task automatic drain_verdicts();
    @(negedge clk);
    start <= 1'b0;
    while (tracker.pending_verdicts.size() != 0) @(posedge clk);
  endtask

  task automatic write_register(logic [CFG_IDX_W-1:0] index, logic [CFG_W-1:0] data);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= index;
    cfg_data <= data;
    do @(posedge clk); while (cfg_ready !== 1'b1);
    tracker.set_register(index, data);
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  initial begin
    #5_000_000;
    $display("[per_key_sliding_window_limiter] ERROR");
    $finish;
  end

  initial begin
    logic [KEY_W-1:0]  key_pool [POOL_KEYS];
    logic [KEY_W-1:0]  req_key;
    logic [TIME_W-1:0] stamp;
    int unsigned       w;
    int                calm_left;
    int                r;
    tracker = new();
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // reset settings: window edge, time wrap and stamps from the future
    send_request(32'h0000_0000, 32'd0);
    send_request(32'h0000_0000, 32'd3600);
    send_request(32'h0000_0000, 32'd3602);
    send_request(32'hFFFF_FFFF, 32'hFFFF_FFFF);
    send_request(32'hFFFF_FFFF, 32'd5);
    send_request(32'hFFFF_FFFF, 32'hFFFF_FFF0);
    drain_verdicts();

    // zero window and hitting the limit
    write_register(REG_MAX_PER_WINDOW, 16'd3);
    write_register(REG_WINDOW_SECONDS, 16'd0);
    repeat (4) send_request(32'h1234_5678, 32'd77);
    send_request(32'h1234_5678, 32'd78);
    drain_verdicts();

    // limiting off, new key must not claim an entry
    write_register(REG_MAX_PER_WINDOW, 16'd0);
    send_request(32'hDEAD_BEEF, 32'd100);
    send_request(32'h0000_0000, 32'd100);
    drain_verdicts();

    foreach (key_pool[i]) key_pool[i] = $urandom;
    key_pool[0] = 32'h0000_0000;
    key_pool[1] = 32'hFFFF_FFFF;
    key_pool[2] = 32'h1234_5678;
    stamp = $urandom;
    calm_left = 0;
    for (int p = 0; p < PHASES; p++) begin
      drain_verdicts();
      if ($urandom_range(0, 1) == 1) begin
        write_register(REG_MAX_PER_WINDOW, PHASE_MAX[p]);
        write_register(REG_WINDOW_SECONDS, PHASE_WINDOW[p]);
      end else begin
        write_register(REG_WINDOW_SECONDS, PHASE_WINDOW[p]);
        write_register(REG_MAX_PER_WINDOW, PHASE_MAX[p]);
      end
      w = PHASE_WINDOW[p];
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        r = $urandom_range(0, 99);
        if (r < 60) stamp += $urandom_range(0, w / 8);
        else if (r < 80) stamp += $urandom_range(0, w + 2);
        else if (r < 90) stamp += w + $urandom_range(0, 1);
        else if (r < 96) stamp -= $urandom_range(1, 64);
        else stamp = $urandom;
        if ($urandom_range(0, 9) == 0) req_key = $urandom;
        else req_key = key_pool[$urandom_range(0, POOL_KEYS - 1)];
        send_request(req_key, stamp);
        if ($urandom_range(0, 49) == 0) drain_verdicts();
        else if (calm_left > 0) calm_left--;
        else if ($urandom_range(0, 9) == 0) calm_left = $urandom_range(5, 20);
        else hold_off($urandom_range(0, 18));
      end
    end

    drain_verdicts();
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (tracker.failures == 0 && tracker.pending_verdicts.size() == 0) begin
      $display("[per_key_sliding_window_limiter] OK");
    end else begin
      $display("[per_key_sliding_window_limiter] ERROR");
    end
    $finish;
  end

endmodule
